@@ hw/rtl/piecewise_linear_color_ramp_top_macros.svh @@
// assertion macros shared by the color ramp checker
`ifndef PIECEWISE_LINEAR_COLOR_RAMP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_COLOR_RAMP_TOP_MACROS_SVH

// same-cycle implication, off while reset is low
`define PLCR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define PLCR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/plcr_pkg.sv @@
// types, constants and helpers of the color ramp
package plcr_pkg;

    localparam int MAX_KNOBS  = 16;
    localparam int TABLE_SIZE = 256;
    localparam int FRAC_BITS  = 4;

    localparam int KNOB_AW = $clog2(MAX_KNOBS);
    localparam int POS_W   = 13;
    localparam int COL_W   = 8;
    localparam int LEVEL_W = 9;
    localparam int SLOT_W  = 4;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 5;
    localparam int NCH     = 4;
    localparam int CH_W    = $clog2(NCH);

    // positions doubled so the sample at i + 0.5 is exact
    localparam int XW     = POS_W + 1;
    localparam int PROD_W = COL_W + XW;
    localparam int REM_W  = PROD_W + 1;
    localparam int STEP_W = $clog2(COL_W);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CH_W-1:0] CH_RED   = CH_W'(0);
    localparam logic [CH_W-1:0] CH_GREEN = CH_W'(1);
    localparam logic [CH_W-1:0] CH_BLUE  = CH_W'(2);
    localparam logic [CH_W-1:0] CH_ALPHA = CH_W'(3);

    typedef logic [COL_W-1:0] color_t;

    typedef struct packed {
        logic [POS_W-1:0]      pos;
        color_t [NCH-1:0]      col;
    } knob_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SEARCH,
        ST_BLEND,
        ST_MULA,
        ST_MULB,
        ST_DIVI,
        ST_DIV,
        ST_FIN
    } state_t;

    // knob height to opacity
    function automatic color_t clamp_level(input logic [LEVEL_W-1:0] lv);
        color_t r;
        if (lv > LEVEL_W'({COL_W{1'b1}})) begin
            r = '1;
        end else begin
            r = lv[COL_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/plcr_ram.sv @@
// generic single-write, single-read ram with registered read data
module plcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/piecewise_linear_color_ramp_top.sv @@
// color ramp top: knob store, segment search and shared multiply/divide sequencer
// a knob write is taken with s_ready left high, so writes can go back to back
// a query holds s_ready low until its word leaves; it reads knob 0, then the last knob, and
// gives the end color if the sample lies outside them; else it walks knob by knob to the
// segment, blending each channel by multiply and divide; a stalled word adds its wait
// synchronous active-low reset clears sequencer and output valid, knob_count to 2, store kept
module piecewise_linear_color_ramp_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [plcr_pkg::CNT_W-1:0] cfg_knob_count,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [plcr_pkg::SLOT_W-1:0]  s_knob_slot,
    input  logic [plcr_pkg::POS_W-1:0]   s_knob_position,
    input  logic [plcr_pkg::COL_W-1:0]   s_knob_red,
    input  logic [plcr_pkg::COL_W-1:0]   s_knob_green,
    input  logic [plcr_pkg::COL_W-1:0]   s_knob_blue,
    input  logic [plcr_pkg::LEVEL_W-1:0] s_knob_level,
    input  logic [plcr_pkg::IDX_W-1:0]   s_query_index,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [plcr_pkg::IDX_W-1:0]   m_entry_index,
    output logic [plcr_pkg::COL_W-1:0]   m_out_red,
    output logic [plcr_pkg::COL_W-1:0]   m_out_green,
    output logic [plcr_pkg::COL_W-1:0]   m_out_blue,
    output logic [plcr_pkg::COL_W-1:0]   m_out_alpha
);

    import plcr_pkg::*;

    // control state
    state_t           state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] knob_count_reg;

    // working registers of the current query
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [XW-1:0]      x_reg, x_next;
    logic [KNOB_AW-1:0] nlast_reg, nlast_next;
    logic [KNOB_AW-1:0] j_reg, j_next;
    knob_t              prev_reg, prev_next;
    knob_t              cur_reg, cur_next;
    logic [XW-1:0]      d_reg, d_next;
    logic [XW-1:0]      wl_reg, wl_next;
    logic [XW-1:0]      wr_reg, wr_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [PROD_W-1:0]  div_reg, div_next;
    logic [COL_W-1:0]   q_reg, q_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    color_t [NCH-1:0]   res_reg, res_next;

    // output register
    logic [IDX_W-1:0]   m_idx_reg, m_idx_next;
    color_t [NCH-1:0]   m_col_reg, m_col_next;

    // knob store
    logic               ram_we;
    logic [KNOB_AW-1:0] ram_waddr;
    knob_t              ram_wdata;
    logic [KNOB_AW-1:0] ram_raddr;
    logic [$bits(knob_t)-1:0] ram_rdata;
    knob_t              kd;

    // helpers
    logic               s_accept;
    logic [IDX_W-1:0]   idx_in;
    logic [XW-1:0]      x0, x1, kx;
    logic               div_ge;
    logic [CH_W-1:0]    ch;
    logic [COL_W:0]     mid_sum;

    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    // out-of-range slots are dropped
    always_comb begin
        ram_we          = s_accept && (s_command == CMD_WRITE) && (int'(s_knob_slot) < MAX_KNOBS);
        ram_waddr       = KNOB_AW'(s_knob_slot);
        ram_wdata.pos   = s_knob_position;
        ram_wdata.col[CH_RED]   = s_knob_red;
        ram_wdata.col[CH_GREEN] = s_knob_green;
        ram_wdata.col[CH_BLUE]  = s_knob_blue;
        ram_wdata.col[CH_ALPHA] = clamp_level(s_knob_level);
    end

    plcr_ram #(
        .WIDTH ($bits(knob_t)),
        .DEPTH (MAX_KNOBS)
    ) u_knob_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign kd     = knob_t'(ram_rdata);
    assign kx     = {kd.pos, 1'b0};
    assign x0     = {prev_reg.pos, 1'b0};
    assign x1     = {cur_reg.pos, 1'b0};
    assign idx_in = IDX_W'(32'(s_query_index) % TABLE_SIZE);
    assign div_ge = rem_reg >= REM_W'(div_reg);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        idx_next     = idx_reg;
        x_next       = x_reg;
        nlast_next   = nlast_reg;
        j_next       = j_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        d_next       = d_reg;
        wl_next      = wl_reg;
        wr_next      = wr_reg;
        ch_next      = ch_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        q_next       = q_reg;
        step_next    = step_reg;
        res_next     = res_reg;
        m_idx_next   = m_idx_reg;
        m_col_next   = m_col_reg;
        ram_raddr    = '0;
        ch           = ch_reg;
        mid_sum      = '0;

        case (state_reg)
            ST_IDLE: begin
                // query: latch the sample point and the clamped last knob, read knob 0
                if (s_accept && (s_command == CMD_QUERY)) begin
                    idx_next = idx_in;
                    x_next   = XW'(((32'(idx_in) << 1) + 32'd1) << FRAC_BITS);
                    if (knob_count_reg < CNT_W'(2)) begin
                        nlast_next = KNOB_AW'(1);
                    end else if (int'(knob_count_reg) > MAX_KNOBS) begin
                        nlast_next = KNOB_AW'(MAX_KNOBS - 1);
                    end else begin
                        nlast_next = KNOB_AW'(knob_count_reg - CNT_W'(1));
                    end
                    ram_raddr  = '0;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                // knob 0 on the read port
                prev_next = kd;
                if (x_reg < kx) begin
                    res_next   = kd.col;
                    state_next = ST_FIN;
                end else begin
                    ram_raddr  = nlast_reg;
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                // last knob on the read port
                if (x_reg > kx) begin
                    res_next   = kd.col;
                    state_next = ST_FIN;
                end else begin
                    j_next     = KNOB_AW'(1);
                    ram_raddr  = KNOB_AW'(1);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // knob j on the read port; walk right until it reaches the sample
                if ((j_reg != nlast_reg) && (x_reg > kx)) begin
                    prev_next = kd;
                    j_next    = j_reg + KNOB_AW'(1);
                    ram_raddr = j_reg + KNOB_AW'(1);
                end else begin
                    cur_next   = kd;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (x1 <= x0) begin
                    // coincident or out-of-order knobs: rounded midpoint
                    for (int c = 0; c < NCH; c++) begin
                        mid_sum     = {1'b0, prev_reg.col[c]} + {1'b0, cur_reg.col[c]}
                                      + (COL_W+1)'(1);
                        res_next[c] = mid_sum[COL_W:1];
                    end
                    state_next = ST_FIN;
                end else if (x_reg <= x0) begin
                    res_next   = prev_reg.col;
                    state_next = ST_FIN;
                end else if (x_reg >= x1) begin
                    res_next   = cur_reg.col;
                    state_next = ST_FIN;
                end else begin
                    d_next     = x1 - x0;
                    wl_next    = x_reg - x0;
                    wr_next    = x1 - x_reg;
                    ch_next    = CH_RED;
                    state_next = ST_MULA;
                end
            end
            ST_MULA: begin
                acc_next   = PROD_W'(prev_reg.col[ch]) * PROD_W'(wr_reg);
                state_next = ST_MULB;
            end
            ST_MULB: begin
                acc_next   = acc_reg + PROD_W'(cur_reg.col[ch]) * PROD_W'(wl_reg);
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                // numerator 2*num + d, divisor 2*d aligned to the top quotient bit
                rem_next   = {acc_reg, 1'b0} + REM_W'(d_reg);
                div_next   = {d_reg, COL_W'(0)};
                q_next     = '0;
                step_next  = STEP_W'(COL_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // one restoring quotient bit per cycle
                if (div_ge) begin
                    rem_next = rem_reg - REM_W'(div_reg);
                end
                q_next    = {q_reg[COL_W-2:0], div_ge};
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    res_next[ch] = {q_reg[COL_W-2:0], div_ge};
                    if (ch_reg == CH_ALPHA) begin
                        state_next = ST_FIN;
                    end else begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_MULA;
                    end
                end
            end
            ST_FIN: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = idx_reg;
                    m_col_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            knob_count_reg <= CNT_W'(2);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                knob_count_reg <= cfg_knob_count;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        x_reg     <= x_next;
        nlast_reg <= nlast_next;
        j_reg     <= j_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        d_reg     <= d_next;
        wl_reg    <= wl_next;
        wr_reg    <= wr_next;
        ch_reg    <= ch_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        q_reg     <= q_next;
        step_reg  <= step_next;
        res_reg   <= res_next;
        m_idx_reg <= m_idx_next;
        m_col_reg <= m_col_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_index = m_idx_reg;
    assign m_out_red     = m_col_reg[CH_RED];
    assign m_out_green   = m_col_reg[CH_GREEN];
    assign m_out_blue    = m_col_reg[CH_BLUE];
    assign m_out_alpha   = m_col_reg[CH_ALPHA];

endmodule

@@ hw/rtl/plcr_checker.sv @@
// port-level checks of the color ramp and their bind to the top level
`include "piecewise_linear_color_ramp_top_macros.svh"

module plcr_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_command,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [plcr_pkg::IDX_W-1:0] m_entry_index,
    input logic [plcr_pkg::COL_W-1:0] m_out_red,
    input logic [plcr_pkg::COL_W-1:0] m_out_green,
    input logic [plcr_pkg::COL_W-1:0] m_out_blue,
    input logic [plcr_pkg::COL_W-1:0] m_out_alpha
);

    import plcr_pkg::*;

    // stalled result word holds
    `PLCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_entry_index) && $stable(m_out_red) && $stable(m_out_green)
            && $stable(m_out_blue) && $stable(m_out_alpha),
        "result word changed while stalled")

    // a knob write never makes a result
    `PLCR_ASSERT_NEXT(a_write_silent, aclk, aresetn,
        s_valid && s_ready && (s_command == CMD_WRITE) && !m_valid, !m_valid,
        "knob write produced a result")

    // a query keeps the input side closed while it is worked on
    `PLCR_ASSERT_NEXT(a_query_busy, aclk, aresetn,
        s_valid && s_ready && (s_command == CMD_QUERY),
        !s_ready && !(m_valid && !$past(m_valid)),
        "query not held busy")

    // a new result only appears at the end of a query, with the input side closed
    `PLCR_ASSERT_NOW(a_result_after_work, aclk, aresetn, $rose(m_valid), !$past(s_ready),
        "result without a query in flight")

endmodule

bind piecewise_linear_color_ramp_top plcr_checker u_plcr_checker (.*);

@@ tb/testbench.sv @@
// self-checking testbench for the color ramp: knob loads, table queries and knob_count settings
`timescale 1ns / 100ps

module testbench;
    import plcr_pkg::*;

    // one command word as the sender puts it on the bus
    typedef struct {
        logic                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    pos;
        logic [COL_W-1:0]    red;
        logic [COL_W-1:0]    green;
        logic [COL_W-1:0]    blue;
        logic [LEVEL_W-1:0]  level;
        logic [IDX_W-1:0]    qidx;
        bit                  drain_first;  // hold this word back until every color word is in
    } ramp_cmd_t;

    // one color word as the block should return it
    typedef struct {
        logic [IDX_W-1:0] entry;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic [COL_W-1:0] alpha;
    } color_word_t;

    // knob_count values, one per phase; covers both clamps and both ends of the legal range
    localparam int PHASES = 10;
    localparam int PHASE_WORDS = 135;
    int unsigned count_plan [PHASES] = '{16, 0, 31, 5, 1, 17, 9, 2, 12, 16};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CNT_W-1:0]    cfg_knob_count = '0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_command = CMD_WRITE;
    logic [SLOT_W-1:0]   s_knob_slot = '0;
    logic [POS_W-1:0]    s_knob_position = '0;
    logic [COL_W-1:0]    s_knob_red = '0;
    logic [COL_W-1:0]    s_knob_green = '0;
    logic [COL_W-1:0]    s_knob_blue = '0;
    logic [LEVEL_W-1:0]  s_knob_level = '0;
    logic [IDX_W-1:0]    s_query_index = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [IDX_W-1:0]    m_entry_index;
    logic [COL_W-1:0]    m_out_red;
    logic [COL_W-1:0]    m_out_green;
    logic [COL_W-1:0]    m_out_blue;
    logic [COL_W-1:0]    m_out_alpha;

    // predictor state: our own copy of the knob store and the register
    logic [POS_W-1:0]    ramp_pos   [MAX_KNOBS];
    logic [COL_W-1:0]    ramp_red   [MAX_KNOBS];
    logic [COL_W-1:0]    ramp_green [MAX_KNOBS];
    logic [COL_W-1:0]    ramp_blue  [MAX_KNOBS];
    logic [LEVEL_W-1:0]  ramp_level [MAX_KNOBS];
    logic [CNT_W-1:0]    knob_count_q = CNT_W'(2);

    ramp_cmd_t   knob_cmds [$];    // words waiting to be driven
    color_word_t owed_colors [$];  // predicted color words, oldest first
    ramp_cmd_t   on_bus;           // copy of the word currently driven

    int send_gap_pct = 12;
    int recv_stall_pct = 57;
    int unsigned pushed = 0;
    int unsigned knob_writes = 0;
    int unsigned queries_taken = 0;  // driver side, blocking
    int unsigned words_seen = 0;     // monitor side, nonblocking so the driver sees a stable value
    int unsigned mismatches = 0;
    int unsigned settings_done = 0;

    always #2 aclk = ~aclk;

    piecewise_linear_color_ramp_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_knob_count  (cfg_knob_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_knob_slot     (s_knob_slot),
        .s_knob_position (s_knob_position),
        .s_knob_red      (s_knob_red),
        .s_knob_green    (s_knob_green),
        .s_knob_blue     (s_knob_blue),
        .s_knob_level    (s_knob_level),
        .s_query_index   (s_query_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entry_index   (m_entry_index),
        .m_out_red       (m_out_red),
        .m_out_green     (m_out_green),
        .m_out_blue      (m_out_blue),
        .m_out_alpha     (m_out_alpha)
    );

    // ---------------------------------------------------------------- predictor

    // height to opacity
    function automatic int unsigned opacity(input logic [LEVEL_W-1:0] lv);
        return (lv > 255) ? 255 : lv;
    endfunction

    // linear mix on doubled positions, rounding half up; equal ends give the midpoint
    function automatic logic [COL_W-1:0] mix_channel(input int unsigned c0, c1, x0, x1, x);
        int unsigned d;
        int unsigned num;
        if (x1 <= x0) return COL_W'((c0 + c1 + 1) >> 1);
        if (x <= x0) return COL_W'(c0);
        if (x >= x1) return COL_W'(c1);
        d = x1 - x0;
        num = c0 * (x1 - x) + c1 * (x - x0);
        return COL_W'((2 * num + d) / (2 * d));
    endfunction

    // color word for table entry idx from the current knobs
    function automatic color_word_t ramp_color(input logic [IDX_W-1:0] idx);
        color_word_t w;
        int unsigned n;
        int unsigned j;
        int unsigned k0;
        int unsigned k1;
        int unsigned x;
        int unsigned x0;
        int unsigned x1;
        n = knob_count_q;
        if (n < 2) n = 2;
        if (n > MAX_KNOBS) n = MAX_KNOBS;
        // sample at idx + 0.5, in half steps of the knob grid
        x = (2 * int'(idx) + 1) << FRAC_BITS;
        if (x < 2 * int'(ramp_pos[0])) begin
            k0 = 0;
            k1 = 0;
        end else if (x > 2 * int'(ramp_pos[n-1])) begin
            k0 = n - 1;
            k1 = n - 1;
        end else begin
            // first right knob at or beyond the sample, sorted or not
            j = 1;
            while (j < n - 1 && x > 2 * int'(ramp_pos[j])) j++;
            k0 = j - 1;
            k1 = j;
        end
        w.entry = idx;
        if (k0 == k1) begin
            w.red   = ramp_red[k0];
            w.green = ramp_green[k0];
            w.blue  = ramp_blue[k0];
            w.alpha = COL_W'(opacity(ramp_level[k0]));
        end else begin
            x0 = 2 * int'(ramp_pos[k0]);
            x1 = 2 * int'(ramp_pos[k1]);
            w.red   = mix_channel(ramp_red[k0], ramp_red[k1], x0, x1, x);
            w.green = mix_channel(ramp_green[k0], ramp_green[k1], x0, x1, x);
            w.blue  = mix_channel(ramp_blue[k0], ramp_blue[k1], x0, x1, x);
            w.alpha = mix_channel(opacity(ramp_level[k0]), opacity(ramp_level[k1]), x0, x1, x);
        end
        return w;
    endfunction

    // ---------------------------------------------------------------- driver

    // valid rises on its own; a word stays put until taken; a drain-first word waits
    // until every query already taken has come back
    always @(posedge aclk) begin : drive_words
        ramp_cmd_t nxt;
        bit        can_load;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (on_bus.cmd == CMD_WRITE) begin
                    ramp_pos[on_bus.slot]   = on_bus.pos;
                    ramp_red[on_bus.slot]   = on_bus.red;
                    ramp_green[on_bus.slot] = on_bus.green;
                    ramp_blue[on_bus.slot]  = on_bus.blue;
                    ramp_level[on_bus.slot] = on_bus.level;
                    knob_writes++;
                end else begin
                    owed_colors.push_back(ramp_color(on_bus.qidx));
                    queries_taken++;
                end
            end
            if (!s_valid || s_ready) begin
                can_load = knob_cmds.size() != 0 && $urandom_range(0, 99) >= send_gap_pct;
                if (can_load && knob_cmds[0].drain_first && queries_taken != words_seen) begin
                    can_load = 1'b0;
                end
                if (can_load) begin
                    nxt = knob_cmds.pop_front();
                    on_bus          <= nxt;
                    s_valid         <= 1'b1;
                    s_command       <= nxt.cmd;
                    s_knob_slot     <= nxt.slot;
                    s_knob_position <= nxt.pos;
                    s_knob_red      <= nxt.red;
                    s_knob_green    <= nxt.green;
                    s_knob_blue     <= nxt.blue;
                    s_knob_level    <= nxt.level;
                    s_query_index   <= nxt.qidx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_field(input string name, input logic [7:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_words
        color_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (owed_colors.size() == 0) begin
                    $error("color word for entry %0d with no query waiting", m_entry_index);
                    mismatches++;
                end else begin
                    want = owed_colors.pop_front();
                    check_field("entry_index", want.entry, m_entry_index);
                    check_field("out_red", want.red, m_out_red);
                    check_field("out_green", want.green, m_out_green);
                    check_field("out_blue", want.blue, m_out_blue);
                    check_field("out_alpha", want.alpha, m_out_alpha);
                    words_seen <= words_seen + 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_write(input int unsigned slot, pos, red, green, blue, level);
        ramp_cmd_t c;
        c = '{default: '0};
        c.cmd   = CMD_WRITE;
        c.slot  = SLOT_W'(slot);
        c.pos   = POS_W'(pos);
        c.red   = COL_W'(red);
        c.green = COL_W'(green);
        c.blue  = COL_W'(blue);
        c.level = LEVEL_W'(level);
        knob_cmds.push_back(c);
        pushed++;
    endtask

    task automatic push_query(input int unsigned idx, input bit drain);
        ramp_cmd_t c;
        c = '{default: '0};
        c.cmd = CMD_QUERY;
        c.qidx = IDX_W'(idx);
        c.drain_first = drain;
        knob_cmds.push_back(c);
        pushed++;
    endtask

    // a sorted ramp over slots 0..n-1 with random colors; some steps are zero so
    // neighbors share a position, and the span often leaves room on either side
    task automatic load_ramp(input int unsigned n);
        int unsigned start;
        int unsigned pos;
        int unsigned step;
        start = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1200);
        pos = start;
        for (int unsigned k = 0; k < n; k++) begin
            push_write(k, pos, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 511));
            step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2 * (4096 - start) / n);
            pos = (pos + step > 4096) ? 4096 : pos + step;
        end
    endtask

    // nothing left to drive, nothing owed, then a short pause for a trailing knob write
    task automatic wait_idle();
        do @(negedge aclk);
        while (knob_cmds.size() != 0 || s_valid || queries_taken != words_seen);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_knob_count(input int unsigned value);
        @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_knob_count <= CNT_W'(value);
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        knob_count_q = CNT_W'(value);
        settings_done++;
    endtask

    initial begin : run
        int unsigned n_eff;
        int unsigned mark;
        int unsigned roll;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset knob_count of 2
        // full span 0..4096: both index extremes and the middle
        push_write(0, 0, 0, 0, 0, 0);
        push_write(1, 4096, 255, 255, 255, 256);
        push_query(0, 1'b0);
        push_query(255, 1'b0);
        push_query(127, 1'b0);
        push_query(128, 1'b0);
        // both knobs on the sample of entry 6: midpoint, heights above 255 clamp
        push_write(0, 104, 255, 0, 170, 511);
        push_write(1, 104, 0, 255, 85, 300);
        push_query(6, 1'b1);
        push_query(0, 1'b0);     // before the first knob
        push_query(200, 1'b0);   // beyond the last knob
        // sample exactly on the left knob, interior, top position code
        push_write(0, 8, 10, 200, 255, 255);
        push_write(1, 8191, 250, 1, 0, 128);
        push_query(0, 1'b0);
        push_query(255, 1'b0);
        push_query(5, 1'b0);
        // sample exactly on the right knob
        push_write(1, 168, 77, 33, 199, 0);
        push_query(10, 1'b0);
        push_query(9, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            // idling: sender light and receiver heavy, then swapped, then none
            if (p == 4) begin
                send_gap_pct = 57;
                recv_stall_pct = 12;
            end else if (p == 7) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            write_knob_count(count_plan[p]);
            n_eff = (count_plan[p] < 2) ? 2 : (count_plan[p] > MAX_KNOBS) ? MAX_KNOBS
                                                                           : count_plan[p];
            // every slot in use is written before the first query of the phase
            load_ramp(n_eff);
            mark = pushed;
            while (pushed - mark < PHASE_WORDS) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    // well-formed: fresh sorted ramp, then a burst of queries
                    load_ramp(n_eff);
                    repeat ($urandom_range(4, 14)) begin
                        push_query($urandom_range(0, 255), $urandom_range(0, 29) == 0);
                    end
                end else if (roll < 85) begin
                    // stray knob, often out of order or past the nominal span
                    push_write($urandom_range(0, 15),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
                                                           : $urandom_range(0, 4096),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 511));
                end else begin
                    push_query($urandom_range(0, 255), 1'b0);
                end
            end
        end

        wait_idle();
        repeat (100) @(posedge aclk);

        if (owed_colors.size() != 0) begin
            $error("%0d color words never arrived", owed_colors.size());
        end
        $display("covered %0d knob writes and %0d queries over %0d knob_count settings",
                 knob_writes, queries_taken, settings_done);
        $display("checked %0d color words, %0d mismatches", words_seen, mismatches);
        if (mismatches == 0 && owed_colors.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/plcr_pkg.sv
hw/rtl/plcr_ram.sv
hw/rtl/piecewise_linear_color_ramp_top.sv
hw/rtl/plcr_checker.sv
tb/testbench.sv
